// ----- hw/rtl/assert_macros.svh -----
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the port-level checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/stcs_pkg.sv -----
// ----------------------------------------------------------------------------
// stcs_pkg
// Widths, constants and controller/datapath interface types of the cubic
// fractional time-shift block.
// ----------------------------------------------------------------------------
package stcs_pkg;

  localparam int SAMPLE_BITS     = 16;
  localparam int SHIFT_FRAC_BITS = 15;
  localparam int SHIFT_BITS      = SHIFT_FRAC_BITS + 1;
  // Weight runs from 0 to 1.0 inclusive, unsigned
  localparam int W_BITS          = SHIFT_FRAC_BITS + 1;
  // Horner accumulator: headroom for coefficient sums of four samples
  localparam int ACC_BITS        = SAMPLE_BITS + 5;
  localparam int PROD_BITS       = ACC_BITS + W_BITS + 1;
  localparam int NUM_STEPS       = 3;
  localparam int STEP_BITS       = 2;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [ACC_BITS-1:0]    acc_t;

  localparam logic [W_BITS-1:0] W_ONE = {1'b1, {SHIFT_FRAC_BITS{1'b0}}};
  localparam logic signed [PROD_BITS-1:0] ROUND_HALF =
    {{(PROD_BITS-SHIFT_FRAC_BITS){1'b0}}, 1'b1, {(SHIFT_FRAC_BITS-1){1'b0}}};
  localparam acc_t ACC_HI = {{(ACC_BITS-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
  localparam acc_t ACC_LO = {{(ACC_BITS-SAMPLE_BITS+1){1'b1}}, {(SAMPLE_BITS-1){1'b0}}};
  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef enum logic [1:0] {
    S_IDLE,
    S_PLAN,
    S_MUL,
    S_EMIT
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic accept;
    logic load;
    logic mul;
    logic emit;
    logic update;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic has_result;
    logic mul_last;
    logic out_free;
  } status_t;

endpackage

// ----- hw/rtl/slice_timing_cubic_shift.sv -----
// ----------------------------------------------------------------------------
// slice_timing_cubic_shift
// Shifts a series of signed samples in time by a signed Q1.15 fraction using
// cubic interpolation with clamped ends and saturated results.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) takes one sample per request, with
//   in_last_of_series marking the final sample of a series. The result
//   channel (out_valid / out_stall) returns corrected samples in order.
//   cfg_wr_en / cfg_wr_data write the shift; write it only while idle.
// Sequence:
//   A request with no result owed returns to idle after planning. Each
//   result it releases takes a window load, three Horner steps on the
//   shared multiplier and a hand-off to the output register; input stays
//   stalled until all are handed off. The last sample flushes up to three
//   results. Forward shifts trail the input by two samples, backward by one.
// Reset:
//   Clears the shift, history, counts and output valid; ready next cycle.
// Stall:
//   A result waits in the output register; the block keeps working and
//   holds the next result until the register frees up.
// ----------------------------------------------------------------------------
module slice_timing_cubic_shift (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    in_valid,
  output logic                                    in_stall,
  input  logic signed [stcs_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                    in_last_of_series,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output logic signed [stcs_pkg::SAMPLE_BITS-1:0] out_corrected_sample,
  output logic                                    out_last_result,
  output logic                                    out_saturated,
  input  logic                                    cfg_wr_en,
  input  logic [stcs_pkg::SHIFT_BITS-1:0]         cfg_wr_data
);
  import stcs_pkg::*;

  cmd_t    cmd;
  status_t status;

  stcs_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  stcs_dp u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .status               (status),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_wr_data          (cfg_wr_data),
    .in_sample            (in_sample),
    .in_last_of_series    (in_last_of_series),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_corrected_sample (out_corrected_sample),
    .out_last_result      (out_last_result),
    .out_saturated        (out_saturated)
  );

endmodule

// ----- hw/rtl/stcs_ctrl.sv -----
// ----------------------------------------------------------------------------
// stcs_ctrl
// Sequencer: accepts a request, then per owed result loads the window, runs
// the three Horner steps and hands the result to the output register; then it updates the history.
// ----------------------------------------------------------------------------
module stcs_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  stcs_pkg::status_t status,
  output stcs_pkg::cmd_t    cmd
);
  import stcs_pkg::*;

  state_t state_r;
  state_t state_nxt;

  // Hold the state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_PLAN;
      end
      S_PLAN: begin
        state_nxt = status.has_result ? S_MUL : S_IDLE;
      end
      S_MUL: begin
        if (status.mul_last) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (status.out_free) state_nxt = S_PLAN;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // Commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_stall   = 1'b0;
        cmd.accept = in_valid;
      end
      S_PLAN: begin
        cmd.load   = status.has_result;
        cmd.update = !status.has_result;
      end
      S_MUL: begin
        cmd.mul = 1'b1;
      end
      S_EMIT: begin
        cmd.emit = status.out_free;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

endmodule

// ----- hw/rtl/stcs_dp.sv -----
// ----------------------------------------------------------------------------
// stcs_dp
// Datapath: shift register, sample history, clamped window selection,
// cubic coefficients, one shared Horner multiplier and the output register.
// ----------------------------------------------------------------------------
module stcs_dp (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  stcs_pkg::cmd_t                         cmd,
  output stcs_pkg::status_t                      status,
  input  logic                                   cfg_wr_en,
  input  logic [stcs_pkg::SHIFT_BITS-1:0]        cfg_wr_data,
  input  logic signed [stcs_pkg::SAMPLE_BITS-1:0] in_sample,
  input  logic                                   in_last_of_series,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic signed [stcs_pkg::SAMPLE_BITS-1:0] out_corrected_sample,
  output logic                                   out_last_result,
  output logic                                   out_saturated
);
  import stcs_pkg::*;

  // Configuration and series state
  logic signed [SHIFT_BITS-1:0] shift_r;
  sample_t                      hist0_r, hist1_r, hist2_r;
  logic [1:0]                   seen_r;
  logic [1:0]                   pend_r;

  // Current request
  sample_t           cur_r;
  logic              last_r;
  logic              fwd_r;
  logic [W_BITS-1:0] w_r;
  logic [1:0]        e_r;
  logic [2:0]        left_r;

  // Horner datapath
  acc_t                 acc_r, a1_r, a2_r, a3_r;
  logic [STEP_BITS-1:0] step_r;

  // Output register
  logic    out_valid_r;
  sample_t out_sample_r;
  logic    out_last_r;
  logic    out_sat_r;

  // Request decode
  logic              fwd_in;
  logic [W_BITS-1:0] w_in;
  logic [2:0]        stop_in;
  logic [2:0]        p_ext;
  logic [2:0]        n_in;
  logic [2:0]        pend_sum;
  logic [1:0]        pend_in;

  always_comb begin
    fwd_in   = !shift_r[SHIFT_BITS-1] && (shift_r != '0);
    w_in     = fwd_in ? W_BITS'(shift_r) : W_BITS'(shift_r) + W_ONE;
    stop_in  = in_last_of_series ? 3'd0 : (fwd_in ? 3'd2 : 3'd1);
    p_ext    = {1'b0, pend_r};
    n_in     = (p_ext >= stop_in) ? (p_ext - stop_in + 3'd1) : 3'd0;
    pend_sum = p_ext + 3'd1 - n_in;
    pend_in  = in_last_of_series ? 2'd0 : pend_sum[1:0];
  end

  // Clamped sample at distance d behind the current one
  function automatic sample_t pick(input logic signed [3:0] d, input logic [1:0] seen,
                                   input sample_t cur, input sample_t h0,
                                   input sample_t h1, input sample_t h2);
    logic signed [3:0] dc;
    sample_t           res;
    dc = (d > $signed({2'b00, seen})) ? $signed({2'b00, seen}) : d;
    if (dc <= 4'sd0) begin
      res = cur;
    end else begin
      case (dc)
        4'sd1:   res = h0;
        4'sd2:   res = h1;
        default: res = h2;
      endcase
    end
    return res;
  endfunction

  // Window and cubic coefficients
  logic [2:0]        base;
  logic signed [3:0] base_s;
  acc_t              p0, p1, p2, p3;
  acc_t              a0, a1, a2;

  always_comb begin
    base   = fwd_r ? ({1'b0, e_r} + 3'd1) : ({1'b0, e_r} + 3'd2);
    base_s = $signed({1'b0, base});
    p0 = ACC_BITS'(pick(base_s,         seen_r, cur_r, hist0_r, hist1_r, hist2_r));
    p1 = ACC_BITS'(pick(base_s - 4'sd1, seen_r, cur_r, hist0_r, hist1_r, hist2_r));
    p2 = ACC_BITS'(pick(base_s - 4'sd2, seen_r, cur_r, hist0_r, hist1_r, hist2_r));
    p3 = ACC_BITS'(pick(base_s - 4'sd3, seen_r, cur_r, hist0_r, hist1_r, hist2_r));
    a0 = p3 - p2 - p0 + p1;
    a1 = p0 - p1 - a0;
    a2 = p2 - p0;
  end

  // One Horner step: round(acc * w) + next coefficient
  logic signed [PROD_BITS-1:0] prod;
  logic signed [PROD_BITS-1:0] prod_rnd;
  logic signed [PROD_BITS-1:0] prod_sh;
  acc_t                        coef;
  acc_t                        acc_step;

  always_comb begin
    case (step_r)
      2'd0:    coef = a1_r;
      2'd1:    coef = a2_r;
      default: coef = a3_r;
    endcase
    prod     = acc_r * $signed({1'b0, w_r});
    prod_rnd = prod + ROUND_HALF;
    prod_sh  = prod_rnd >>> SHIFT_FRAC_BITS;
    acc_step = $signed(prod_sh[ACC_BITS-1:0]) + coef;
  end

  // Saturate the finished value
  logic    sat_hi, sat_lo;
  sample_t sat_val;

  always_comb begin
    sat_hi  = acc_r > ACC_HI;
    sat_lo  = acc_r < ACC_LO;
    sat_val = sat_hi ? SAMPLE_MAX : (sat_lo ? SAMPLE_MIN : acc_r[SAMPLE_BITS-1:0]);
  end

  // Status
  always_comb begin
    status.has_result = left_r != 3'd0;
    status.mul_last   = step_r == STEP_BITS'(NUM_STEPS - 1);
    status.out_free   = !out_valid_r || !out_stall;
  end

  // Shift register write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
    end else if (cfg_wr_en) begin
      shift_r <= $signed(cfg_wr_data);
    end
  end

  // Series state: pending count advances at accept, history at update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hist0_r <= '0;
      hist1_r <= '0;
      hist2_r <= '0;
      seen_r  <= '0;
      pend_r  <= '0;
    end else begin
      if (cmd.accept) pend_r <= pend_in;
      if (cmd.update) begin
        if (last_r) begin
          hist0_r <= '0;
          hist1_r <= '0;
          hist2_r <= '0;
          seen_r  <= '0;
        end else begin
          hist2_r <= hist1_r;
          hist1_r <= hist0_r;
          hist0_r <= cur_r;
          if (seen_r != 2'd3) seen_r <= seen_r + 2'd1;
        end
      end
    end
  end

  // Result countdown
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= '0;
    end else if (cmd.accept) begin
      left_r <= n_in;
    end else if (cmd.emit) begin
      left_r <= left_r - 3'd1;
    end
  end

  // Request fields and result index
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      cur_r  <= in_sample;
      last_r <= in_last_of_series;
      fwd_r  <= fwd_in;
      w_r    <= w_in;
      e_r    <= pend_r;
    end else if (cmd.emit) begin
      e_r <= e_r - 2'd1;
    end
  end

  // Horner step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
    end else if (cmd.load) begin
      step_r <= '0;
    end else if (cmd.mul && !status.mul_last) begin
      step_r <= step_r + STEP_BITS'(1);
    end
  end

  // Load coefficients, then advance the accumulator
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      acc_r <= a0;
      a1_r  <= a1;
      a2_r  <= a2;
      a3_r  <= p1;
    end else if (cmd.mul) begin
      acc_r <= acc_step;
    end
  end

  // Output register: drop when taken, load on emit
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_sample_r <= sat_val;
      out_last_r   <= last_r && (e_r == 2'd0);
      out_sat_r    <= sat_hi || sat_lo;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_corrected_sample = out_sample_r;
  assign out_last_result      = out_last_r;
  assign out_saturated        = out_sat_r;

endmodule

// ----- hw/rtl/stcs_checker.sv -----
// ----------------------------------------------------------------------------
// stcs_checker
// Port-level checks of the cubic time-shift block, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module stcs_checker (
  input logic                                    clk,
  input logic                                    rst_n,
  input logic                                    in_valid,
  input logic                                    in_stall,
  input logic                                    out_valid,
  input logic                                    out_stall,
  input logic signed [stcs_pkg::SAMPLE_BITS-1:0] out_corrected_sample,
  input logic                                    out_last_result,
  input logic                                    out_saturated
);
  import stcs_pkg::*;

  logic in_acc;
  logic out_hold;
  logic sat_seen;
  logic at_rail;

  assign in_acc   = in_valid && !in_stall;
  assign out_hold = out_valid && out_stall;
  assign sat_seen = out_valid && out_saturated;
  assign at_rail  = (out_corrected_sample == SAMPLE_MAX) ||
                    (out_corrected_sample == SAMPLE_MIN);

  // A stalled result keeps its value
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_hold, out_valid && $stable(out_corrected_sample) && $stable(out_last_result) && $stable(out_saturated), "stalled result changed")

  // A clipped result sits on a rail of the sample range
  `ASSERT_IMPLIES(a_sat_rail, clk, rst_n, sat_seen, at_rail, "saturated result off the rail")

  // One request at a time: the input closes after each accept
  `ASSERT_NEXT(a_one_req, clk, rst_n, in_acc, in_stall, "input open right after accept")

  // No result appears in the cycle after an accept from an empty output
  `ASSERT_NEXT(a_no_early, clk, rst_n, in_acc && !out_valid, !out_valid, "result too early")

endmodule

bind slice_timing_cubic_shift stcs_checker u_stcs_checker (
  .clk                  (clk),
  .rst_n                (rst_n),
  .in_valid             (in_valid),
  .in_stall             (in_stall),
  .out_valid            (out_valid),
  .out_stall            (out_stall),
  .out_corrected_sample (out_corrected_sample),
  .out_last_result      (out_last_result),
  .out_saturated        (out_saturated)
);
